@@ rtl/core/bpd_pkg.sv @@
package bpd_pkg;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_COUNT    = 4'd1,
		PH_FSIZE    = 4'd2,
		PH_FHEAD    = 4'd3,
		PH_FDATA    = 4'd4,
		PH_FLAGSCAP = 4'd5,
		PH_FLAGS    = 4'd6,
		PH_CMD      = 4'd7,
		PH_SKIP     = 4'd8,
		PH_EXTSIZE  = 4'd9,
		PH_PAYLOAD  = 4'd10
	} phase_t;

	localparam logic [5:0] SIZE_ESCAPE = 6'h3F;
	localparam int         FLAG_REUSE  = 0;
	localparam int         FLAG_SHORT  = 1;
	localparam logic [7:0] MARKER      = 8'hFF;
	localparam logic [2:0] LONG_SKIP   = 3'd4;
	localparam logic [2:0] SHORT_SKIP  = 3'd1;

	typedef struct packed {
		logic       vld;
		logic [7:0] out_byte;
		logic [7:0] packet_number;
		logic       last_in_packet;
		logic       last_in_batch;
	} res_t;

endpackage

@@ rtl/core/bpd_parse.sv @@
module bpd_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [7:0]    data_byte,
	input  logic          batch_start,
	output bpd_pkg::res_t res
);

	bpd_pkg::phase_t phase_q, phase_d;
	logic [7:0] packets_left_q, packets_left_d;
	logic [7:0] bytes_left_q, bytes_left_d;
	logic [7:0] saved_command_q, saved_command_d;
	logic [7:0] pending_flags_q, pending_flags_d;
	logic [2:0] skip_count_q, skip_count_d;
	logic [7:0] current_packet_q, current_packet_d;

	logic       emit;
	logic       last;
	logic [7:0] bl_chk;
	logic [2:0] skip_dec;

	assign skip_dec = skip_count_q - 3'd1;

	// result for the request in flight
	always_comb begin
		emit   = 1'b0;
		bl_chk = bytes_left_q;
		case (phase_q)
			bpd_pkg::PH_FHEAD, bpd_pkg::PH_FDATA, bpd_pkg::PH_PAYLOAD: begin
				emit   = 1'b1;
				bl_chk = bytes_left_q - 8'd1;
			end
			bpd_pkg::PH_SKIP: begin
				emit = (skip_dec == 3'd0) && (pending_flags_q[7:2] != bpd_pkg::SIZE_ESCAPE);
			end
			bpd_pkg::PH_EXTSIZE: begin
				emit   = 1'b1;
				bl_chk = data_byte;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		emit = emit && en && !batch_start;
		last = (bl_chk == 8'd0);

		res.vld            = emit;
		res.out_byte       = (phase_q == bpd_pkg::PH_SKIP || phase_q == bpd_pkg::PH_EXTSIZE) ?
			saved_command_q : data_byte;
		res.packet_number  = current_packet_q;
		res.last_in_packet = last;
		res.last_in_batch  = last && (packets_left_q == 8'd0);
	end

	always_comb begin
		phase_d          = phase_q;
		packets_left_d   = packets_left_q;
		bytes_left_d     = bytes_left_q;
		saved_command_d  = saved_command_q;
		pending_flags_d  = pending_flags_q;
		skip_count_d     = skip_count_q;
		current_packet_d = current_packet_q;
		if (batch_start) begin
			phase_d          = (data_byte == bpd_pkg::MARKER) ? bpd_pkg::PH_COUNT : bpd_pkg::PH_IDLE;
			packets_left_d   = '0;
			bytes_left_d     = '0;
			saved_command_d  = '0;
			pending_flags_d  = '0;
			skip_count_d     = '0;
			current_packet_d = '0;
		end else begin
			case (phase_q)
				bpd_pkg::PH_IDLE: begin
					phase_d = bpd_pkg::PH_IDLE;
				end
				bpd_pkg::PH_COUNT: begin
					packets_left_d = (data_byte > 8'd1) ? data_byte - 8'd1 : 8'd0;
					phase_d        = bpd_pkg::PH_FSIZE;
				end
				bpd_pkg::PH_FSIZE: begin
					current_packet_d = 8'd1;
					if (data_byte == 8'd0) begin
						if (packets_left_q == 8'd0) begin
							phase_d = bpd_pkg::PH_IDLE;
						end else begin
							packets_left_d   = packets_left_q - 8'd1;
							current_packet_d = 8'd2;
							phase_d          = bpd_pkg::PH_FLAGSCAP;
						end
					end else begin
						bytes_left_d = data_byte;
						phase_d      = bpd_pkg::PH_FHEAD;
					end
				end
				bpd_pkg::PH_FHEAD: begin
					saved_command_d = data_byte;
					bytes_left_d    = bl_chk;
					phase_d         = bpd_pkg::PH_FDATA;
				end
				bpd_pkg::PH_FDATA, bpd_pkg::PH_PAYLOAD: begin
					bytes_left_d = bl_chk;
				end
				bpd_pkg::PH_FLAGSCAP, bpd_pkg::PH_FLAGS: begin
					if (phase_q == bpd_pkg::PH_FLAGSCAP) begin
						saved_command_d = data_byte;
					end
					pending_flags_d = data_byte;
					bytes_left_d    = {2'b00, data_byte[7:2]};
					if (data_byte[bpd_pkg::FLAG_REUSE]) begin
						skip_count_d = bpd_pkg::SHORT_SKIP;
						phase_d      = bpd_pkg::PH_SKIP;
					end else begin
						phase_d = bpd_pkg::PH_CMD;
					end
				end
				bpd_pkg::PH_CMD: begin
					saved_command_d = data_byte;
					skip_count_d    = pending_flags_q[bpd_pkg::FLAG_SHORT] ?
						bpd_pkg::SHORT_SKIP : bpd_pkg::LONG_SKIP;
					phase_d         = bpd_pkg::PH_SKIP;
				end
				bpd_pkg::PH_SKIP: begin
					skip_count_d = skip_dec;
					if (skip_dec == 3'd0) begin
						phase_d = (pending_flags_q[7:2] == bpd_pkg::SIZE_ESCAPE) ?
							bpd_pkg::PH_EXTSIZE : bpd_pkg::PH_PAYLOAD;
					end
				end
				bpd_pkg::PH_EXTSIZE: begin
					bytes_left_d = data_byte;
					phase_d      = bpd_pkg::PH_PAYLOAD;
				end
				default: begin
					phase_d = bpd_pkg::PH_IDLE;
				end
			endcase
			// close the sub-packet on its final byte
			if (emit && last) begin
				if (packets_left_q == 8'd0) begin
					phase_d = bpd_pkg::PH_IDLE;
				end else begin
					packets_left_d   = packets_left_q - 8'd1;
					current_packet_d = current_packet_q + 8'd1;
					phase_d          = bpd_pkg::PH_FLAGS;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= bpd_pkg::PH_IDLE;
			packets_left_q   <= '0;
			bytes_left_q     <= '0;
			saved_command_q  <= '0;
			pending_flags_q  <= '0;
			skip_count_q     <= '0;
			current_packet_q <= '0;
		end else if (en) begin
			phase_q          <= phase_d;
			packets_left_q   <= packets_left_d;
			bytes_left_q     <= bytes_left_d;
			saved_command_q  <= saved_command_d;
			pending_flags_q  <= pending_flags_d;
			skip_count_q     <= skip_count_d;
			current_packet_q <= current_packet_d;
		end
	end

endmodule

@@ rtl/core/bpd_out_stage.sv @@
module bpd_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  bpd_pkg::res_t res,
	output logic          ready,
	output logic          result_valid,
	input  logic          result_stall,
	output logic [7:0]    out_byte,
	output logic [7:0]    packet_number,
	output logic          last_in_packet,
	output logic          last_in_batch
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic [7:0] pkt_q;
	logic       lpkt_q;
	logic       lbat_q;

	assign ready = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= en && res.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && en && res.vld) begin
			byte_q <= res.out_byte;
			pkt_q  <= res.packet_number;
			lpkt_q <= res.last_in_packet;
			lbat_q <= res.last_in_batch;
		end
	end

	assign result_valid   = valid_q;
	assign out_byte       = byte_q;
	assign packet_number  = pkt_q;
	assign last_in_packet = lpkt_q;
	assign last_in_batch  = lbat_q;

endmodule

@@ rtl/core/batch_packet_deframer.sv @@
// Splits a byte stream of batch messages into sub-packets, command byte first,
// tagged with packet number and end-of-packet / end-of-batch flags. One byte per
// cycle sustained while result_stall is low: each byte is registered, decoded
// by the header/payload state machine combinationally, and its result (if any)
// lands in an output register; result_stall backs up into item_stall only while
// a byte waits in the input register.
module batch_packet_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] data_byte,
	input  logic       batch_start,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic [7:0] packet_number,
	output logic       last_in_packet,
	output logic       last_in_batch
);

	logic          valid_s1;
	logic [7:0]    data_s1;
	logic          start_s1;
	logic          advance;
	logic          take;
	bpd_pkg::res_t res;

	assign item_stall = valid_s1 && !advance;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1  <= data_byte;
			start_s1 <= batch_start;
		end
	end

	bpd_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (valid_s1 && advance),
		.data_byte   (data_s1),
		.batch_start (start_s1),
		.res         (res)
	);

	bpd_out_stage u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (valid_s1),
		.res            (res),
		.ready          (advance),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.out_byte       (out_byte),
		.packet_number  (packet_number),
		.last_in_packet (last_in_packet),
		.last_in_batch  (last_in_batch)
	);

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("input stalled without a blocked result");

	a_batch_end_is_packet_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!last_in_batch || last_in_packet))
		else $error("batch end without packet end");

	a_packet_number_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (packet_number != 8'd0))
		else $error("result carries packet number zero");

endmodule

@@ bench/testbench.sv @@
module testbench;

	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 200;
	localparam int HOLD_CYCLES = 300;
	localparam int DIR_ROWS    = 29;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] pkt_num;
		logic       end_pkt;
		logic       end_batch;
	} sub_byte_t;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} msg_byte_t;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_SILENT,
		ROW_EMITS
	} row_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
		row_kind_t  kind;
		sub_byte_t  res;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic [7:0] data_byte = 8'h00;
	logic       batch_start = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [7:0] out_byte;
	logic [7:0] packet_number;
	logic       last_in_packet;
	logic       last_in_batch;

	batch_packet_deframer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.data_byte      (data_byte),
		.batch_start    (batch_start),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.out_byte       (out_byte),
		.packet_number  (packet_number),
		.last_in_packet (last_in_packet),
		.last_in_batch  (last_in_batch)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// deframer state mirror
	bpd_pkg::phase_t ph = bpd_pkg::PH_IDLE;
	logic [7:0] left_pkts = 8'd0;
	logic [7:0] left_bytes = 8'd0;
	logic [7:0] cmd = 8'd0;
	logic [7:0] flags = 8'd0;
	logic [2:0] skips = 3'd0;
	logic [7:0] cur_pkt = 8'd0;

	sub_byte_t expected_bytes[$];
	msg_byte_t stim_q[$];
	int        errors = 0;
	int        cycles = 0;
	int        tx_idle_pct = 0;
	int        rx_stall_pct = 0;
	int        hold_reqs = 0;

	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{8'hFF, 1'b1, ROW_SILENT,  '0},
		'{8'h03, 1'b0, ROW_PREDICT, '0},
		'{8'h02, 1'b0, ROW_PREDICT, '0},
		'{8'hAB, 1'b0, ROW_EMITS,   '{8'hAB, 8'd1, 1'b0, 1'b0}},
		'{8'h00, 1'b0, ROW_EMITS,   '{8'h00, 8'd1, 1'b1, 1'b0}},
		'{8'h05, 1'b0, ROW_PREDICT, '0},
		'{8'h77, 1'b0, ROW_PREDICT, '0},
		'{8'hFF, 1'b0, ROW_PREDICT, '0},
		'{8'hFC, 1'b0, ROW_PREDICT, '0},
		'{8'h5A, 1'b0, ROW_PREDICT, '0},
		'{8'h00, 1'b0, ROW_PREDICT, '0},
		'{8'hFF, 1'b0, ROW_PREDICT, '0},
		'{8'h00, 1'b0, ROW_PREDICT, '0},
		'{8'hFF, 1'b0, ROW_PREDICT, '0},
		'{8'h00, 1'b0, ROW_EMITS,   '{8'h5A, 8'd3, 1'b1, 1'b1}},
		// restart mid-batch with a bad marker, then an ignored byte
		'{8'hFF, 1'b1, ROW_SILENT,  '0},
		'{8'h09, 1'b0, ROW_PREDICT, '0},
		'{8'h00, 1'b1, ROW_SILENT,  '0},
		'{8'h01, 1'b0, ROW_SILENT,  '0},
		// empty first sub-packet
		'{8'hFF, 1'b1, ROW_SILENT,  '0},
		'{8'h02, 1'b0, ROW_PREDICT, '0},
		'{8'h00, 1'b0, ROW_PREDICT, '0},
		'{8'h06, 1'b0, ROW_PREDICT, '0},
		'{8'h33, 1'b0, ROW_PREDICT, '0},
		'{8'h00, 1'b0, ROW_PREDICT, '0},
		'{8'h80, 1'b0, ROW_PREDICT, '0},
		// count zero, empty first: silent end
		'{8'hFF, 1'b1, ROW_SILENT,  '0},
		'{8'h00, 1'b0, ROW_PREDICT, '0},
		'{8'h00, 1'b0, ROW_PREDICT, '0}
	};

	task automatic clear_state();
		ph = bpd_pkg::PH_IDLE;
		left_pkts = 8'd0;
		left_bytes = 8'd0;
		cmd = 8'd0;
		flags = 8'd0;
		skips = 3'd0;
		cur_pkt = 8'd0;
	endtask

	task automatic emit(input logic [7:0] b, output sub_byte_t r);
		r.data = b;
		r.pkt_num = cur_pkt;
		r.end_pkt = (left_bytes == 8'd0);
		r.end_batch = (left_bytes == 8'd0) && (left_pkts == 8'd0);
		if (left_bytes == 8'd0) begin
			if (left_pkts == 8'd0) begin
				ph = bpd_pkg::PH_IDLE;
			end else begin
				left_pkts = left_pkts - 8'd1;
				cur_pkt = cur_pkt + 8'd1;
				ph = bpd_pkg::PH_FLAGS;
			end
		end
	endtask

	task automatic take_flags(input logic [7:0] b);
		flags = b;
		left_bytes = {2'b00, b[7:2]};
		if (b[bpd_pkg::FLAG_REUSE]) begin
			skips = bpd_pkg::SHORT_SKIP;
			ph = bpd_pkg::PH_SKIP;
		end else begin
			ph = bpd_pkg::PH_CMD;
		end
	endtask

	task automatic deframe_step(input logic [7:0] b, input logic st, output bit got,
			output sub_byte_t r);
		got = 1'b0;
		r = '0;
		if (st) begin
			clear_state();
			if (b == bpd_pkg::MARKER)
				ph = bpd_pkg::PH_COUNT;
		end else begin
			case (ph)
				bpd_pkg::PH_COUNT: begin
					left_pkts = (b > 8'd1) ? b - 8'd1 : 8'd0;
					ph = bpd_pkg::PH_FSIZE;
				end
				bpd_pkg::PH_FSIZE: begin
					cur_pkt = 8'd1;
					if (b == 8'd0) begin
						if (left_pkts == 8'd0) begin
							ph = bpd_pkg::PH_IDLE;
						end else begin
							left_pkts = left_pkts - 8'd1;
							cur_pkt = 8'd2;
							ph = bpd_pkg::PH_FLAGSCAP;
						end
					end else begin
						left_bytes = b;
						ph = bpd_pkg::PH_FHEAD;
					end
				end
				bpd_pkg::PH_FHEAD, bpd_pkg::PH_FDATA, bpd_pkg::PH_PAYLOAD: begin
					if (ph == bpd_pkg::PH_FHEAD) begin
						cmd = b;
						ph = bpd_pkg::PH_FDATA;
					end
					left_bytes = left_bytes - 8'd1;
					emit(b, r);
					got = 1'b1;
				end
				bpd_pkg::PH_FLAGSCAP: begin
					cmd = b;
					take_flags(b);
				end
				bpd_pkg::PH_FLAGS: begin
					take_flags(b);
				end
				bpd_pkg::PH_CMD: begin
					cmd = b;
					skips = flags[bpd_pkg::FLAG_SHORT] ? bpd_pkg::SHORT_SKIP :
						bpd_pkg::LONG_SKIP;
					ph = bpd_pkg::PH_SKIP;
				end
				bpd_pkg::PH_SKIP: begin
					skips = skips - 3'd1;
					if (skips == 3'd0) begin
						if (flags[7:2] == bpd_pkg::SIZE_ESCAPE) begin
							ph = bpd_pkg::PH_EXTSIZE;
						end else begin
							ph = bpd_pkg::PH_PAYLOAD;
							emit(cmd, r);
							got = 1'b1;
						end
					end
				end
				bpd_pkg::PH_EXTSIZE: begin
					left_bytes = b;
					ph = bpd_pkg::PH_PAYLOAD;
					emit(cmd, r);
					got = 1'b1;
				end
				default: begin
					ph = bpd_pkg::PH_IDLE;
				end
			endcase
		end
	endtask

	// called at a rising edge; returns at the edge that takes the request
	task automatic offer(input logic [7:0] d, input logic st);
		bit taken;
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		data_byte <= d;
		batch_start <= st;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !item_stall;
			@(posedge clk);
		end
	endtask

	task automatic queue_batch(input bit huge, output int n_batch);
		msg_byte_t b[$];
		int        cnt;
		int        fsize;
		int        sz;
		int        n;
		int        lim;
		int        roll;
		logic [7:0] fl;
		b.push_back('{bpd_pkg::MARKER, 1'b1});
		cnt = huge ? 255 : $urandom_range(0, 6);
		b.push_back('{8'(cnt), 1'b0});
		roll = $urandom_range(99);
		if (huge)
			fsize = 1;
		else if (roll < 3)
			fsize = 255;
		else
			fsize = $urandom_range(0, 8);
		b.push_back('{8'(fsize), 1'b0});
		for (int i = 0; i < fsize; i++)
			b.push_back('{8'($urandom), 1'b0});
		for (int k = 2; k <= cnt; k++) begin
			if (huge) begin
				sz = $urandom_range(0, 1);
				fl = {6'(sz), 1'($urandom_range(0, 1)), 1'b1};
			end else begin
				roll = $urandom_range(99);
				if (roll < 10)
					sz = bpd_pkg::SIZE_ESCAPE;
				else if (roll < 20)
					sz = $urandom_range(9, 62);
				else
					sz = $urandom_range(0, 8);
				fl = {6'(sz), 2'($urandom_range(0, 3))};
			end
			b.push_back('{fl, 1'b0});
			if (fl[bpd_pkg::FLAG_REUSE]) begin
				b.push_back('{8'($urandom), 1'b0});
			end else begin
				b.push_back('{8'($urandom), 1'b0});
				repeat (fl[bpd_pkg::FLAG_SHORT] ? 1 : 4)
					b.push_back('{8'($urandom), 1'b0});
			end
			if (sz == bpd_pkg::SIZE_ESCAPE) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
				b.push_back('{8'(n), 1'b0});
			end else begin
				n = sz;
			end
			for (int i = 0; i < n; i++)
				b.push_back('{8'($urandom), 1'b0});
		end
		lim = b.size();
		if (!huge && $urandom_range(9) == 0)
			lim = $urandom_range(1, b.size());
		for (int i = 0; i < lim; i++)
			stim_q.push_back(b[i]);
		n_batch = lim;
		// stray bytes, some flagged as starts
		if (!huge && $urandom_range(7) == 0) begin
			repeat ($urandom_range(1, 4))
				stim_q.push_back('{8'($urandom), 1'($urandom_range(0, 3) == 0)});
		end
	endtask

	task automatic play_queue();
		msg_byte_t m;
		sub_byte_t r;
		bit        got;
		while (stim_q.size() != 0) begin
			m = stim_q.pop_front();
			offer(m.data, m.start);
			deframe_step(m.data, m.start, got, r);
			if (got)
				expected_bytes.push_back(r);
		end
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		int holds_seen;
		hold_left = 0;
		holds_seen = 0;
		forever begin
			@(posedge clk);
			if (holds_seen != hold_reqs) begin
				holds_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	always @(negedge clk) begin
		sub_byte_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected request: out_byte=%0h packet_number=%0d", out_byte,
					packet_number);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.data) begin
					$error("out_byte expected %0h actual %0h", want.data, out_byte);
					errors++;
				end
				if (packet_number !== want.pkt_num) begin
					$error("packet_number expected %0d actual %0d", want.pkt_num,
						packet_number);
					errors++;
				end
				if (last_in_packet !== want.end_pkt) begin
					$error("last_in_packet expected %0b actual %0b", want.end_pkt,
						last_in_packet);
					errors++;
				end
				if (last_in_batch !== want.end_batch) begin
					$error("last_in_batch expected %0b actual %0b", want.end_batch,
						last_in_batch);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int        sent;
		int        n;
		sub_byte_t r;
		bit        got;
		int        tx_by_phase [0:4];
		int        rx_by_phase [0:4];
		tx_by_phase = '{0, 87, 0, 25, 0};
		rx_by_phase = '{0, 0, 87, 25, 0};
		clear_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			offer(dir_rows[i].data, dir_rows[i].start);
			deframe_step(dir_rows[i].data, dir_rows[i].start, got, r);
			if (dir_rows[i].kind == ROW_EMITS)
				expected_bytes.push_back(dir_rows[i].res);
			else if (dir_rows[i].kind == ROW_PREDICT && got)
				expected_bytes.push_back(r);
		end

		for (int p = 0; p < 5; p++) begin
			tx_idle_pct = tx_by_phase[p];
			rx_stall_pct = rx_by_phase[p];
			sent = 0;
			if (p == 0) begin
				queue_batch(1'b1, n);
				play_queue();
			end
			if (p == 4)
				hold_reqs++;
			while (sent < PHASE_ITEMS) begin
				queue_batch(1'b0, n);
				sent += n;
				play_queue();
			end
		end

		item_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/bpd_pkg.sv
rtl/core/bpd_parse.sv
rtl/core/bpd_out_stage.sv
rtl/core/batch_packet_deframer.sv
bench/testbench.sv
